// ===== sv/qte_pkg.sv =====
package qte_pkg;

  localparam int WORK_FRAC = 28;
  // working word: products and sums reach about 37 * 2^28 inside the cordic
  localparam int WW        = 40;
  // angle accumulator, 2^31 = pi, plus guard bits for the half-turn offset
  localparam int AW        = 34;
  // floor square root of a 57-bit operand: one result bit per stage
  localparam int SQ_STAGES = 29;
  localparam int REM_W     = 57;
  localparam int RES_W     = 58;
  localparam int SABS_W    = 29;

  localparam int MQ_DEPTH  = 4;
  localparam int MQ_AW     = 2;
  localparam int OQ_DEPTH  = 2;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [WW-1:0] roll_y;
    logic signed [WW-1:0] roll_x;
    logic signed [WW-1:0] yaw_y;
    logic signed [WW-1:0] yaw_x;
    logic signed [WW-1:0] sin_p;
    logic                 clamped;
  } entry_t;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } result_t;

endpackage

// ===== sv/qte_front.sv =====
module qte_front import qte_pkg::*; #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_x_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_y_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_z_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_w_i,
  output logic                             ent_valid_o,
  output entry_t                           ent_o
);

  localparam int SH  = 2 * (COMPONENT_BITS - 2) - WORK_FRAC;
  localparam int SHR = (SH > 0) ? SH : 0;
  localparam int SHL = (SH < 0) ? -SH : 0;
  localparam logic signed [WW-1:0] ONE = WW'(1) <<< WORK_FRAC;

  function automatic logic signed [WW-1:0] mul_work(
    input logic signed [COMPONENT_BITS-1:0] a,
    input logic signed [COMPONENT_BITS-1:0] b
  );
    logic signed [2*COMPONENT_BITS-1:0] p;
    logic signed [63:0]                 pw;
    p  = a * b;
    pw = 64'(p);
    return WW'((pw >>> SHR) <<< SHL);
  endfunction

  logic signed [WW-1:0] xx_q, yy_q, zz_q, wx_q, yz_q, wy_q, xz_q, wz_q, xy_q;
  logic                 vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      xx_q <= mul_work(quat_x_i, quat_x_i);
      yy_q <= mul_work(quat_y_i, quat_y_i);
      zz_q <= mul_work(quat_z_i, quat_z_i);
      wx_q <= mul_work(quat_w_i, quat_x_i);
      yz_q <= mul_work(quat_y_i, quat_z_i);
      wy_q <= mul_work(quat_w_i, quat_y_i);
      xz_q <= mul_work(quat_x_i, quat_z_i);
      wz_q <= mul_work(quat_w_i, quat_z_i);
      xy_q <= mul_work(quat_x_i, quat_y_i);
    end
  end

  logic signed [WW-1:0] s_raw;

  always_comb begin
    s_raw          = (wy_q - xz_q) <<< 1;
    ent_o.roll_y   = (wx_q + yz_q) <<< 1;
    ent_o.roll_x   = ONE - ((xx_q + yy_q) <<< 1);
    ent_o.yaw_y    = (wz_q + xy_q) <<< 1;
    ent_o.yaw_x    = ONE - ((yy_q + zz_q) <<< 1);
    ent_o.sin_p    = s_raw;
    ent_o.clamped  = 1'b0;
    // saturate the arcsine argument to the unit interval
    if (s_raw > ONE) begin
      ent_o.sin_p   = ONE;
      ent_o.clamped = 1'b1;
    end else if (s_raw < -ONE) begin
      ent_o.sin_p   = -ONE;
      ent_o.clamped = 1'b1;
    end
  end

  assign ent_valid_o = vld_q;

endmodule

// ===== sv/qte_fifo.sv =====
module qte_fifo import qte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  entry_t           wdata_i,
  input  logic             rd_i,
  output entry_t           rdata_o,
  output logic             empty_o,
  output logic [MQ_AW:0]   count_o
);

  entry_t             mem_q [MQ_DEPTH];
  logic [MQ_AW-1:0]   wp_q, rp_q;
  logic [MQ_AW:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (MQ_AW+1)'(wr_i) - (MQ_AW+1)'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ===== sv/qte_cordic.sv =====
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WW-1:0] y_i,
  input  logic signed [WW-1:0] x_i,
  output logic signed [AW-1:0] ang_o
);

  localparam logic signed [AW-1:0] PI = AW'(1) <<< 31;

  logic signed [WW-1:0] xs_q [STEPS];
  logic signed [WW-1:0] ys_q [STEPS];
  logic signed [AW-1:0] an_q [STEPS+1];
  logic                 zr_q [STEPS+1];

  // quadrant fold: a vector in the left half-plane is turned by a half turn
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        an_q[0] <= (y_i >= 0) ? PI : -PI;
        xs_q[0] <= -x_i;
        ys_q[0] <= -y_i;
      end else begin
        an_q[0] <= '0;
        xs_q[0] <= x_i;
        ys_q[0] <= y_i;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [WW-1:0] dx, dy;
    logic signed [AW-1:0] da;
    assign dx = ys_q[i] >>> i;
    assign dy = xs_q[i] >>> i;
    assign da = signed'(AW'(ATAN_TAB[i]));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zr_q[i+1] <= zr_q[i];
        an_q[i+1] <= (ys_q[i] >= 0) ? an_q[i] + da : an_q[i] - da;
      end
    end

    if (i < STEPS - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (ys_q[i] >= 0) begin
            xs_q[i+1] <= xs_q[i] + dx;
            ys_q[i+1] <= ys_q[i] - dy;
          end else begin
            xs_q[i+1] <= xs_q[i] - dx;
            ys_q[i+1] <= ys_q[i] + dy;
          end
        end
      end
    end
  end

  assign ang_o = zr_q[STEPS] ? '0 : an_q[STEPS];

endmodule

// ===== sv/qte_back.sv =====
module qte_back import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    in_valid_i,
  input  entry_t  in_ent_i,
  output logic    pop_o,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int LAT = SQ_STAGES + CORDIC_STEPS + 3;
  localparam logic [RES_W-1:0] FULL_SQ = RES_W'(1) << (2 * WORK_FRAC);

  logic [LAT-1:0] vld_q, cl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) cl_q <= {cl_q[LAT-2:0], in_ent_i.clamped};
  end

  assign pop_o = adv_i && in_valid_i;

  // 1 - s^2 for the cosine of pitch
  logic [SABS_W-1:0] s_abs;
  logic [RES_W-1:0]  s_sq;
  logic signed [WW-1:0] s_neg;
  assign s_neg = -in_ent_i.sin_p;
  assign s_abs = (in_ent_i.sin_p < 0) ? s_neg[SABS_W-1:0] : in_ent_i.sin_p[SABS_W-1:0];
  assign s_sq  = RES_W'(s_abs) * RES_W'(s_abs);

  logic signed [WW-1:0] ry_q [SQ_STAGES+1];
  logic signed [WW-1:0] rx_q [SQ_STAGES+1];
  logic signed [WW-1:0] yy_q [SQ_STAGES+1];
  logic signed [WW-1:0] yx_q [SQ_STAGES+1];
  logic signed [WW-1:0] sp_q [SQ_STAGES+1];
  logic [REM_W-1:0]     rem_q [SQ_STAGES+1];
  logic [RES_W-1:0]     res_q [SQ_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ry_q[0]  <= in_ent_i.roll_y;
      rx_q[0]  <= in_ent_i.roll_x;
      yy_q[0]  <= in_ent_i.yaw_y;
      yx_q[0]  <= in_ent_i.yaw_x;
      sp_q[0]  <= in_ent_i.sin_p;
      rem_q[0] <= REM_W'(FULL_SQ - s_sq);
      res_q[0] <= '0;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    localparam int K = SQ_STAGES - 1 - j;
    logic [RES_W-1:0] bitv, trial;
    assign bitv  = RES_W'(1) << (2 * K);
    assign trial = res_q[j] + bitv;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ry_q[j+1] <= ry_q[j];
        rx_q[j+1] <= rx_q[j];
        yy_q[j+1] <= yy_q[j];
        yx_q[j+1] <= yx_q[j];
        sp_q[j+1] <= sp_q[j];
        if (RES_W'(rem_q[j]) >= trial) begin
          rem_q[j+1] <= REM_W'(RES_W'(rem_q[j]) - trial);
          res_q[j+1] <= (res_q[j] >> 1) + bitv;
        end else begin
          rem_q[j+1] <= rem_q[j];
          res_q[j+1] <= res_q[j] >> 1;
        end
      end
    end
  end

  logic signed [WW-1:0] cos_p;
  assign cos_p = WW'(res_q[SQ_STAGES][SABS_W-1:0]);

  logic signed [AW-1:0] a_roll, a_yaw, a_pitch;

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk_i(clk_i), .en_i(adv_i),
    .y_i(ry_q[SQ_STAGES]), .x_i(rx_q[SQ_STAGES]), .ang_o(a_roll)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk_i(clk_i), .en_i(adv_i),
    .y_i(yy_q[SQ_STAGES]), .x_i(yx_q[SQ_STAGES]), .ang_o(a_yaw)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i(clk_i), .en_i(adv_i),
    .y_i(sp_q[SQ_STAGES]), .x_i(cos_p), .ang_o(a_pitch)
  );

  // round to 16-bit binary angles
  logic signed [AW-17:0] t_roll, t_yaw, t_pitch;
  logic signed [AW-1:0]  half;
  assign half    = AW'(32768);
  assign t_roll  = (AW-16)'((a_roll + half) >>> 16);
  assign t_yaw   = (AW-16)'((a_yaw + half) >>> 16);
  assign t_pitch = (AW-16)'((a_pitch + half) >>> 16);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o.roll    <= t_roll[15:0];
      res_o.yaw     <= t_yaw[15:0];
      res_o.clamped <= cl_q[LAT-2];
      if (t_pitch > (AW-16)'(16384)) begin
        res_o.pitch <= 16'sd16384;
      end else if (t_pitch < -(AW-16)'(16384)) begin
        res_o.pitch <= -16'sd16384;
      end else begin
        res_o.pitch <= t_pitch[15:0];
      end
    end
  end

  assign res_valid_o = vld_q[LAT-1];

endmodule

// ===== sv/quaternion_to_euler_zyx.sv =====
// quaternion to z-y-x euler angle converter
//
// input channel: drive quat_x_i..quat_w_i (signed, two fraction bits short of
// the component width, q2.14 by default) and raise push; a beat is taken on a
// rising edge with push high and full low. one beat per cycle is sustained
// while full stays low. result channel: while empty is low the oldest result
// sits on yaw_o, pitch_o, roll_o and pitch_clamped_o; raising pop takes it.
// angles are binary angles with 32768 = pi; pitch_clamped_o flags a saturated
// arcsine. an input beat passes the front product registers (sums and clamp
// are combinational), a 4-entry decoupling queue, the 29-stage square root,
// the fold plus CORDIC_STEPS cordic stages and a rounding stage. throughput
// is one beat per cycle while the receiver keeps pace, set by the fully
// pipelined cordic lanes and square root stages.
// when the receiver stalls, the back pipeline halts once a result reaches
// a full 2-entry output queue; the middle queue then fills and full rises.
// reset (rst_ni low) empties every queue and drops all beats in flight.
module quaternion_to_euler_zyx import qte_pkg::*; #(
  parameter int CORDIC_STEPS   = 16,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [COMPONENT_BITS-1:0] quat_x_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_y_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_z_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_w_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [15:0]               yaw_o,
  output logic signed [15:0]               pitch_o,
  output logic signed [15:0]               roll_o,
  output logic                             pitch_clamped_o
);

  // front: products and argument forming
  logic   accept;
  logic   f_valid;
  entry_t f_ent;

  assign accept = push && !full;

  qte_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .accept_i(accept),
    .quat_x_i(quat_x_i), .quat_y_i(quat_y_i),
    .quat_z_i(quat_z_i), .quat_w_i(quat_w_i),
    .ent_valid_o(f_valid), .ent_o(f_ent)
  );

  // decoupling queue between front and back
  entry_t         mq_rdata;
  logic           mq_empty;
  logic [MQ_AW:0] mq_cnt;
  logic           mq_pop;

  qte_fifo u_mq (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_i(f_valid), .wdata_i(f_ent),
    .rd_i(mq_pop), .rdata_o(mq_rdata),
    .empty_o(mq_empty), .count_o(mq_cnt)
  );

  // leave room for the beat already in the front stage
  assign full = ((MQ_AW+2)'(mq_cnt) + (MQ_AW+2)'(f_valid)) >= (MQ_AW+2)'(MQ_DEPTH);

  // back: square root and cordic lanes
  logic    adv;
  logic    b_valid;
  result_t b_res;

  qte_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .adv_i(adv),
    .in_valid_i(!mq_empty), .in_ent_i(mq_rdata), .pop_o(mq_pop),
    .res_valid_o(b_valid), .res_o(b_res)
  );

  // output queue, parts the back pipeline from the receiver
  result_t    oq_q [OQ_DEPTH];
  logic       oq_wp_q, oq_rp_q;
  logic [1:0] oq_cnt_q;
  logic       oq_wr, oq_rd;

  assign adv   = !(b_valid && (oq_cnt_q == 2'(OQ_DEPTH)));
  assign oq_wr = b_valid && adv;
  assign oq_rd = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= 1'b0;
      oq_rp_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_wr) oq_wp_q <= ~oq_wp_q;
      if (oq_rd) oq_rp_q <= ~oq_rp_q;
      oq_cnt_q <= oq_cnt_q + 2'(oq_wr) - 2'(oq_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_wr) oq_q[oq_wp_q] <= b_res;
  end

  assign empty           = (oq_cnt_q == '0);
  assign yaw_o           = oq_q[oq_rp_q].yaw;
  assign pitch_o         = oq_q[oq_rp_q].pitch;
  assign roll_o          = oq_q[oq_rp_q].roll;
  assign pitch_clamped_o = oq_q[oq_rp_q].clamped;

  // middle queue is never written when full
  a_mq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid |-> (mq_cnt < (MQ_AW+1)'(MQ_DEPTH)))
    else $error("middle queue overflow");

  // back never pulls from an empty middle queue
  a_mq_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_pop |-> !mq_empty)
    else $error("middle queue underflow");

  // a finished result only moves into an output queue with room
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_wr |-> (oq_cnt_q != 2'(OQ_DEPTH)))
    else $error("output queue overflow");

  // output queue count stays within depth
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= 2'(OQ_DEPTH))
    else $error("output queue count out of range");

endmodule

// ===== tb/tb_quaternion_to_euler_zyx_checker.sv =====
module tb_quaternion_to_euler_zyx_checker #(
  parameter int CORDIC_STEPS   = 16,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic                             full_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_x_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_y_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_z_i,
  input  logic signed [COMPONENT_BITS-1:0] quat_w_i,
  input  logic                             empty_i,
  input  logic                             pop_i,
  input  logic signed [15:0]               yaw_i,
  input  logic signed [15:0]               pitch_i,
  input  logic signed [15:0]               roll_i,
  input  logic                             pitch_clamped_i,
  output int                               err_cnt_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_W = 64'sd1 <<< 28;
  localparam longint PI_A  = 64'sd2147483648;

  localparam longint ATAN_LUT [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic               clamped;
  } euler_t;

  euler_t euler_q[$];
  int     err_n  = 0;
  int     pend_n = 0;

  // product rescaled to 28 fraction bits
  function automatic longint prod_w(longint a, longint b);
    int sh;
    sh = 2 * (COMPONENT_BITS - 2) - 28;
    if (sh > 0) return (a * b) >>> sh;
    return (a * b) <<< (-sh);
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint a, dx, dy;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = (y >= 0) ? PI_A : -PI_A;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> (i % 32);
      dy = x >>> (i % 32);
      if (y >= 0) begin
        x += dx; y -= dy; a += ATAN_LUT[i % 32];
      end else begin
        x -= dx; y += dy; a -= ATAN_LUT[i % 32];
      end
    end
    return a;
  endfunction

  function automatic longint bam16(longint a);
    return (a + 32768) >>> 16;
  endfunction

  function automatic euler_t to_euler(longint x, longint y, longint z, longint w);
    euler_t e;
    longint s, c, p;
    e.roll = 16'(bam16(vec_angle(2 * (prod_w(w, x) + prod_w(y, z)),
                                 ONE_W - 2 * (prod_w(x, x) + prod_w(y, y)))));
    e.yaw  = 16'(bam16(vec_angle(2 * (prod_w(w, z) + prod_w(x, y)),
                                 ONE_W - 2 * (prod_w(y, y) + prod_w(z, z)))));
    s = 2 * (prod_w(w, y) - prod_w(x, z));
    e.clamped = 1'b0;
    if (s > ONE_W) begin
      s = ONE_W; e.clamped = 1'b1;
    end else if (s < -ONE_W) begin
      s = -ONE_W; e.clamped = 1'b1;
    end
    c = root_floor(ONE_W * ONE_W - s * s);
    p = bam16(vec_angle(s, c));
    if (p > 16384) p = 16384;
    if (p < -16384) p = -16384;
    e.pitch = 16'(p);
    return e;
  endfunction

  assign err_cnt_o = err_n;
  assign pending_o = pend_n;

  always @(posedge clk_i) begin
    euler_t exp_e;
    if (rst_ni) begin
      if (push_i && !full_i)
        euler_q.push_back(to_euler(quat_x_i, quat_y_i, quat_z_i, quat_w_i));
      if (pop_i && !empty_i) begin
        if (euler_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_n++;
        end else begin
          exp_e = euler_q.pop_front();
          if (yaw_i !== exp_e.yaw) begin
            $error("yaw: expected %0d, got %0d", exp_e.yaw, yaw_i);
            err_n++;
          end
          if (pitch_i !== exp_e.pitch) begin
            $error("pitch: expected %0d, got %0d", exp_e.pitch, pitch_i);
            err_n++;
          end
          if (roll_i !== exp_e.roll) begin
            $error("roll: expected %0d, got %0d", exp_e.roll, roll_i);
            err_n++;
          end
          if (pitch_clamped_i !== exp_e.clamped) begin
            $error("pitch_clamped: expected %0b, got %0b", exp_e.clamped,
                   pitch_clamped_i);
            err_n++;
          end
        end
      end
      pend_n = euler_q.size();
    end
  end
endmodule

// ===== tb/tb_quaternion_to_euler_zyx.sv =====
module tb_quaternion_to_euler_zyx;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = 16;
  localparam int N_RANDOM  = 2000;
  localparam int LATENCY   = 16 + 34;
  localparam int CYC_LIMIT = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 pop = 1'b0;
  logic                 full, empty;
  logic signed [CB-1:0] qx = '0, qy = '0, qz = '0, qw = '0;
  logic signed [15:0]   yaw, pitch, roll;
  logic                 clamp;
  int                   err_cnt, pending;
  int                   cyc = 0;
  bit                   rx_hold = 1'b0;  // long receiver stall request

  always #5 clk_i = ~clk_i;

  quaternion_to_euler_zyx #(.CORDIC_STEPS(16), .COMPONENT_BITS(CB)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .empty(empty), .pop(pop), .yaw_o(yaw), .pitch_o(pitch), .roll_o(roll),
    .pitch_clamped_o(clamp)
  );

  tb_quaternion_to_euler_zyx_checker #(.CORDIC_STEPS(16), .COMPONENT_BITS(CB)) u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .full_i(full),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .empty_i(empty), .pop_i(pop), .yaw_i(yaw), .pitch_i(pitch), .roll_i(roll),
    .pitch_clamped_i(clamp), .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("tb_quaternion_to_euler_zyx: done, errors");
      $finish;
    end
  end

  // send one beat after an idle gap given by gap; push stays high across back-to-back beats
  task automatic send_quat(logic [CB-1:0] x, logic [CB-1:0] y,
                           logic [CB-1:0] z, logic [CB-1:0] w, int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    qx <= x; qy <= y; qz <= z; qw <= w;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // draw a gap: random outside a burst, none within one, for runs of no idling
  function automatic int pick_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // near-unit quaternion with random direction, scaled by a random factor
  task automatic send_rotation(int gap);
    real a, b, c, d, n, k;
    a = real'($urandom_range(0, 2000)) - 1000.0;
    b = real'($urandom_range(0, 2000)) - 1000.0;
    c = real'($urandom_range(0, 2000)) - 1000.0;
    d = real'($urandom_range(0, 2000)) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    k = 16384.0 * (0.9 + real'($urandom_range(0, 200)) / 1000.0) / n;
    send_quat(CB'($rtoi(a * k)), CB'($rtoi(b * k)), CB'($rtoi(c * k)),
              CB'($rtoi(d * k)), gap);
  endtask

  // receiver: random stall per beat, plus the long hold when requested
  initial begin
    int wait_cyc;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        pop <= 1'b0;
      end else begin
        wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (wait_cyc > 0) begin
          pop <= 1'b0;
          repeat (wait_cyc) @(negedge clk_i);
        end
        pop <= 1'b1;
        @(posedge clk_i);
        while (empty) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [CB-1:0] mx, mn, hf;
    int            n_wait;
    bit            burst;
    mx = 16'h7fff; mn = 16'h8000; hf = 16'h4000;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: identity, axis turns, zeros, extremes, clamp both ways
    send_quat(0, 0, 0, hf, 0);
    send_quat(0, 0, 0, 0, 0);             // zero quaternion: all products vanish
    send_quat(hf, 0, 0, 0, 0);            // roll of pi
    send_quat(0, hf, 0, 0, 0);            // roll and yaw paths, negative x args
    send_quat(0, 0, hf, 0, 0);            // yaw of pi
    send_quat(0, 16'sd11585, 0, 16'sd11585, 0);   // pitch near +half pi
    send_quat(0, -16'sd11585, 0, 16'sd11585, 0);  // pitch near -half pi
    send_quat(0, mx, 0, mx, 0);           // clamp high
    send_quat(0, mn, 0, mx, 0);           // clamp low
    send_quat(mx, mx, mx, mx, 1);
    send_quat(mn, mn, mn, mn, 0);
    send_quat(mx, mn, mx, mn, 2);
    send_quat(mn, mx, mn, mx, 0);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
    send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001, 0);
    send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
    send_quat(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
    send_quat(mx, 0, 0, 0, 0);
    send_quat(0, 0, mn, 0, 0);
    send_quat(0, 0, 0, mn, 0);

    // long receiver stall while the sender keeps pushing, so full rises
    rx_hold = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_rotation(0);
    join

    // random: mostly near-unit rotations, some raw noise
    burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 49) == 0) burst = ~burst;
      if ($urandom_range(0, 3) == 0)
        send_quat(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
                  pick_gap(burst));
      else
        send_rotation(pick_gap(burst));
      // sender pause: let everything drain once mid-run
      if (i == N_RANDOM / 2) begin
        push <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    push <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    n_wait = LATENCY + 20;
    repeat (n_wait) @(negedge clk_i);
    if (err_cnt == 0)
      $display("tb_quaternion_to_euler_zyx: done, clean");
    else
      $display("tb_quaternion_to_euler_zyx: done, errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/qte_pkg.sv
sv/qte_front.sv
sv/qte_fifo.sv
sv/qte_cordic.sv
sv/qte_back.sv
sv/quaternion_to_euler_zyx.sv
tb/tb_quaternion_to_euler_zyx_checker.sv
tb/tb_quaternion_to_euler_zyx.sv
